FILE: hdl/tga_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Shared types and constants of the run-length TGA pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_pkg;

	typedef enum logic [0:0] {
		OP_BYTE = 1'b0,
		OP_PULL = 1'b1
	} op_t;

	localparam logic [4:0] HEADER_BYTES = 5'd18;
	localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;

	localparam logic [7:0] RAW_LIMIT = 8'd128;
	localparam logic [7:0] REPEAT_BIAS = 8'd127;

	localparam logic [1:0] PHASE_BLUE = 2'd0;
	localparam logic [1:0] PHASE_GREEN = 2'd1;
	localparam logic [1:0] PHASE_RED = 2'd2;

	typedef struct packed {
		op_t op;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [15:0] column;
		logic [15:0] row;
		logic last_pixel;
	} pixel_t;

	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/tga_if.sv
// ----------------------------------------------------------------------------
// TGA decoder channels
// Valid/ready channels for stream requests and decoded pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tga_byte_if;
	logic valid;
	logic ready;
	logic [0:0] operation;
	logic [7:0] data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface tga_pixel_if;
	logic valid;
	logic ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [15:0] column;
	logic [15:0] row;
	logic last_pixel;

	modport source (
		output valid, output red, output green, output blue,
		output column, output row, output last_pixel, input ready
	);
	modport sink (
		input valid, input red, input green, input blue,
		input column, input row, input last_pixel, output ready
	);
endinterface

`default_nettype wire

FILE: hdl/tga_rle_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder core
// Parses a run-length-compressed 24-bit TGA stream and returns decoded pixels
// with their column and row on pull requests.
// ----------------------------------------------------------------------------
// The block takes one request per cycle unless stalled: a stream byte or a
// pull for the next pixel. A request passes through an input register and is
// applied to the parser state when the parser advances. A pull that finds a
// pixel ready loads the output register in that same step, so a pixel passes
// the input register, then the output register. The output register stalls
// the parser only while a pixel waits there and the sink is not ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_core (
	input  wire logic clk,
	input  wire logic arst_n,
	tga_byte_if.sink  byte_in,
	tga_pixel_if.source pixel_out
);

	tga_pkg::stage_ctrl_t ctrl;
	tga_pkg::item_t       item;
	tga_pkg::pixel_t      result;
	tga_pkg::pixel_t      pixel_q;
	logic                 result_valid;
	logic                 out_valid_q;
	logic                 advance;

	assign advance = !out_valid_q || pixel_out.ready;

	tga_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.advance (advance),
		.ctrl    (ctrl),
		.item    (item)
	);

	tga_rle_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result_valid) begin
			pixel_q <= result;
		end
	end

	assign pixel_out.valid = out_valid_q;
	assign pixel_out.red = pixel_q.red;
	assign pixel_out.green = pixel_q.green;
	assign pixel_out.blue = pixel_q.blue;
	assign pixel_out.column = pixel_q.column;
	assign pixel_out.row = pixel_q.row;
	assign pixel_out.last_pixel = pixel_q.last_pixel;

endmodule

`default_nettype wire

FILE: hdl/tga_in_stage.sv
// ----------------------------------------------------------------------------
// TGA input stage
// Registers one request and hands it to the parser when the result side can
// take what it produces.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	tga_byte_if.sink            byte_in,
	input  wire logic           advance,
	output tga_pkg::stage_ctrl_t ctrl,
	output tga_pkg::item_t      item
);

	logic           valid_s1;
	tga_pkg::item_t item_s1;

	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			item_s1.op <= tga_pkg::op_t'(byte_in.operation);
			item_s1.data <= byte_in.data_byte;
		end
	end

	assign ctrl.valid = valid_s1;
	assign ctrl.advance = advance;
	assign item = item_s1;

endmodule

`default_nettype wire

FILE: hdl/tga_rle_parser.sv
// ----------------------------------------------------------------------------
// TGA RLE parser
// Holds the header, packet and pixel position state and applies one request
// per step, producing at most one decoded pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  tga_pkg::stage_ctrl_t ctrl,
	input  tga_pkg::item_t       item,
	output logic                 result_valid,
	output tga_pkg::pixel_t      result
);

	logic [4:0]  header_count_q, header_count_d;
	logic [15:0] image_width_q, image_width_d;
	logic [15:0] image_height_q, image_height_d;
	logic [15:0] column_count_q, column_count_d;
	logic [15:0] row_count_q, row_count_d;
	logic [7:0]  packet_left_q, packet_left_d;
	logic        raw_packet_q, raw_packet_d;
	logic        color_ready_q, color_ready_d;
	logic [1:0]  byte_phase_q, byte_phase_d;
	logic [7:0]  blue_hold_q, blue_hold_d;
	logic [7:0]  green_hold_q, green_hold_d;
	logic [7:0]  red_hold_q, red_hold_d;

	logic        step;
	logic        in_header;
	logic        last;
	logic [7:0]  left_after;

	assign step = ctrl.valid && ctrl.advance;
	assign in_header = header_count_q < tga_pkg::HEADER_BYTES;
	assign last = (row_count_q == 16'd1) && (column_count_q == image_width_q);
	assign left_after = packet_left_q - 8'd1;

	always_comb begin
		header_count_d = header_count_q;
		image_width_d = image_width_q;
		image_height_d = image_height_q;
		column_count_d = column_count_q;
		row_count_d = row_count_q;
		packet_left_d = packet_left_q;
		raw_packet_d = raw_packet_q;
		color_ready_d = color_ready_q;
		byte_phase_d = byte_phase_q;
		blue_hold_d = blue_hold_q;
		green_hold_d = green_hold_q;
		red_hold_d = red_hold_q;
		result_valid = 1'b0;

		result.red = red_hold_q;
		result.green = green_hold_q;
		result.blue = blue_hold_q;
		result.column = column_count_q;
		result.row = row_count_q;
		result.last_pixel = last;

		if (item.op == tga_pkg::OP_BYTE) begin
			if (in_header) begin
				case (header_count_q)
					tga_pkg::HDR_WIDTH_LO: image_width_d[7:0] = item.data;
					tga_pkg::HDR_WIDTH_HI: image_width_d[15:8] = item.data;
					tga_pkg::HDR_HEIGHT_LO: image_height_d[7:0] = item.data;
					tga_pkg::HDR_HEIGHT_HI: image_height_d[15:8] = item.data;
					default: ;
				endcase
				header_count_d = header_count_q + 5'd1;
				if (header_count_d == tga_pkg::HEADER_BYTES) begin
					column_count_d = 16'd1;
					packet_left_d = 8'd0;
					color_ready_d = 1'b0;
					byte_phase_d = tga_pkg::PHASE_BLUE;
					if (image_width_d == 16'd0 || image_height_d == 16'd0) begin
						header_count_d = 5'd0;
						row_count_d = 16'd0;
						raw_packet_d = 1'b0;
					end else begin
						row_count_d = image_height_d;
					end
				end
			end else if (!color_ready_q) begin
				if (packet_left_q == 8'd0) begin
					if (item.data < tga_pkg::RAW_LIMIT) begin
						packet_left_d = item.data + 8'd1;
						raw_packet_d = 1'b1;
					end else begin
						packet_left_d = item.data - tga_pkg::REPEAT_BIAS;
						raw_packet_d = 1'b0;
					end
					byte_phase_d = tga_pkg::PHASE_BLUE;
				end else begin
					case (byte_phase_q)
						tga_pkg::PHASE_BLUE: begin
							blue_hold_d = item.data;
							byte_phase_d = tga_pkg::PHASE_GREEN;
						end
						tga_pkg::PHASE_GREEN: begin
							green_hold_d = item.data;
							byte_phase_d = tga_pkg::PHASE_RED;
						end
						default: begin
							red_hold_d = item.data;
							byte_phase_d = tga_pkg::PHASE_BLUE;
							color_ready_d = 1'b1;
						end
					endcase
				end
			end
		end else if (!in_header && color_ready_q) begin
			result_valid = 1'b1;
			if (last) begin
				header_count_d = 5'd0;
				column_count_d = 16'd1;
				row_count_d = 16'd0;
				packet_left_d = 8'd0;
				raw_packet_d = 1'b0;
				color_ready_d = 1'b0;
				byte_phase_d = tga_pkg::PHASE_BLUE;
			end else begin
				if (column_count_q == image_width_q) begin
					column_count_d = 16'd1;
					row_count_d = row_count_q - 16'd1;
				end else begin
					column_count_d = column_count_q + 16'd1;
				end
				packet_left_d = left_after;
				if (left_after == 8'd0 || raw_packet_q) begin
					color_ready_d = 1'b0;
					byte_phase_d = tga_pkg::PHASE_BLUE;
				end
			end
		end

		if (!step) begin
			result_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= 5'd0;
			image_width_q <= 16'd0;
			image_height_q <= 16'd0;
			column_count_q <= 16'd1;
			row_count_q <= 16'd0;
			packet_left_q <= 8'd0;
			raw_packet_q <= 1'b0;
			color_ready_q <= 1'b0;
			byte_phase_q <= tga_pkg::PHASE_BLUE;
			blue_hold_q <= 8'd0;
			green_hold_q <= 8'd0;
			red_hold_q <= 8'd0;
		end else if (step) begin
			header_count_q <= header_count_d;
			image_width_q <= image_width_d;
			image_height_q <= image_height_d;
			column_count_q <= column_count_d;
			row_count_q <= row_count_d;
			packet_left_q <= packet_left_d;
			raw_packet_q <= raw_packet_d;
			color_ready_q <= color_ready_d;
			byte_phase_q <= byte_phase_d;
			blue_hold_q <= blue_hold_d;
			green_hold_q <= green_hold_d;
			red_hold_q <= red_hold_d;
		end
	end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Sends TGA stream bytes and pixel pulls to the decoder. A short table of
// requests comes first, then a stream of random images is built from the
// decoder state that the testbench tracks. Every pixel that comes out is
// compared with the predicted one, with random stalls on both channels.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int ITEM_TARGET = 1350;
	localparam int PRESSURE_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 10;

	typedef enum {RES_MODEL, RES_NONE, RES_TYPED} result_kind_t;

	typedef struct {
		tga_pkg::op_t op;
		logic [7:0] data;
		result_kind_t kind;
		tga_pkg::pixel_t typed;
	} stim_row_t;

	typedef struct {
		logic [4:0] taken;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] column;
		logic [15:0] row;
		logic [7:0] left;
		logic raw;
		logic ready;
		logic [1:0] phase;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} decoder_t;

	logic clk;
	logic arst_n;

	tga_byte_if req_ch();
	tga_pixel_if pix_ch();

	tga_rle_pixel_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(req_ch),
		.pixel_out(pix_ch)
	);

	decoder_t dec;
	tga_pkg::pixel_t pending_pixels[$];
	stim_row_t directed_rows[$];
	result_kind_t cur_kind;
	tga_pkg::pixel_t cur_typed;
	int stream_items;
	int pixels_seen;
	int fail_count;
	int quiet_cycles;
	int send_calm;
	int noise_left;
	int wide_left;
	logic [15:0] next_width;
	logic [15:0] next_height;

	function automatic void await_header();
		dec.taken = '0;
		dec.column = 16'd1;
		dec.row = '0;
		dec.left = '0;
		dec.raw = 1'b0;
		dec.ready = 1'b0;
		dec.phase = tga_pkg::PHASE_BLUE;
	endfunction

	function automatic bit is_ignored(input tga_pkg::op_t op);
		if (op == tga_pkg::OP_PULL)
			return (dec.taken < tga_pkg::HEADER_BYTES) || !dec.ready;
		return (dec.taken >= tga_pkg::HEADER_BYTES) && dec.ready;
	endfunction

	function automatic bit decode_request(input tga_pkg::op_t op, input logic [7:0] data,
			output tga_pkg::pixel_t px);
		bit last;
		px = '0;
		if (op == tga_pkg::OP_BYTE) begin
			if (dec.taken < tga_pkg::HEADER_BYTES) begin
				case (dec.taken)
					tga_pkg::HDR_WIDTH_LO: dec.width[7:0] = data;
					tga_pkg::HDR_WIDTH_HI: dec.width[15:8] = data;
					tga_pkg::HDR_HEIGHT_LO: dec.height[7:0] = data;
					tga_pkg::HDR_HEIGHT_HI: dec.height[15:8] = data;
					default: ;
				endcase
				dec.taken = dec.taken + 5'd1;
				if (dec.taken == tga_pkg::HEADER_BYTES) begin
					if (dec.width == 16'd0 || dec.height == 16'd0) begin
						await_header();
					end else begin
						dec.column = 16'd1;
						dec.row = dec.height;
						dec.left = '0;
						dec.ready = 1'b0;
						dec.phase = tga_pkg::PHASE_BLUE;
					end
				end
			end else if (!dec.ready) begin
				if (dec.left == 8'd0) begin
					if (data < tga_pkg::RAW_LIMIT) begin
						dec.left = data + 8'd1;
						dec.raw = 1'b1;
					end else begin
						dec.left = data - tga_pkg::REPEAT_BIAS;
						dec.raw = 1'b0;
					end
					dec.phase = tga_pkg::PHASE_BLUE;
				end else begin
					case (dec.phase)
						tga_pkg::PHASE_BLUE: begin
							dec.blue = data;
							dec.phase = tga_pkg::PHASE_GREEN;
						end
						tga_pkg::PHASE_GREEN: begin
							dec.green = data;
							dec.phase = tga_pkg::PHASE_RED;
						end
						default: begin
							dec.red = data;
							dec.phase = tga_pkg::PHASE_BLUE;
							dec.ready = 1'b1;
						end
					endcase
				end
			end
			return 1'b0;
		end
		if (dec.taken < tga_pkg::HEADER_BYTES || !dec.ready)
			return 1'b0;
		last = (dec.row == 16'd1) && (dec.column == dec.width);
		px = '{red: dec.red, green: dec.green, blue: dec.blue,
			column: dec.column, row: dec.row, last_pixel: last};
		if (last) begin
			await_header();
			return 1'b1;
		end
		if (dec.column == dec.width) begin
			dec.column = 16'd1;
			dec.row = dec.row - 16'd1;
		end else begin
			dec.column = dec.column + 16'd1;
		end
		dec.left = dec.left - 8'd1;
		if (dec.left == 8'd0 || dec.raw) begin
			dec.ready = 1'b0;
			dec.phase = tga_pkg::PHASE_BLUE;
		end
		return 1'b1;
	endfunction

	function automatic int pick_idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_packet_header();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 8'($urandom_range(0, 7));
		if (r < 55)
			return 8'($urandom_range(0, 127));
		if (r < 58)
			return 8'h7F;
		if (r < 88)
			return 8'($urandom_range(128, 135));
		if (r < 96)
			return 8'($urandom_range(128, 255));
		return 8'hFF;
	endfunction

	function automatic void pick_image_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			if ($urandom_range(0, 1) == 0) begin
				next_width = '0;
				next_height = 16'($urandom);
			end else begin
				next_width = 16'($urandom);
				next_height = '0;
			end
		end else if (r < 8 && wide_left > 0) begin
			wide_left--;
			next_width = 16'($urandom_range(256, 300));
			next_height = 16'd1;
		end else begin
			next_width = 16'($urandom_range(1, 8));
			next_height = 16'($urandom_range(1, 6));
		end
	endfunction

	function automatic void choose_request(output tga_pkg::op_t op, output logic [7:0] data);
		if (dec.taken < tga_pkg::HEADER_BYTES)
			noise_left = 0;
		else if (noise_left == 0 && $urandom_range(0, 199) < 3)
			noise_left = $urandom_range(1, 6);
		op = tga_pkg::OP_BYTE;
		data = 8'($urandom);
		if (noise_left > 0) begin
			noise_left--;
			op = tga_pkg::op_t'($urandom_range(0, 1));
		end else if (dec.taken < tga_pkg::HEADER_BYTES) begin
			if ($urandom_range(0, 99) < 3)
				op = tga_pkg::OP_PULL;
			else begin
				case (dec.taken)
					tga_pkg::HDR_WIDTH_LO: begin
						pick_image_size();
						data = next_width[7:0];
					end
					tga_pkg::HDR_WIDTH_HI: data = next_width[15:8];
					tga_pkg::HDR_HEIGHT_LO: data = next_height[7:0];
					tga_pkg::HDR_HEIGHT_HI: data = next_height[15:8];
					default: ;
				endcase
			end
		end else if (dec.ready) begin
			if ($urandom_range(0, 99) < 93)
				op = tga_pkg::OP_PULL;
		end else if ($urandom_range(0, 99) < 4) begin
			op = tga_pkg::OP_PULL;
		end else if (dec.left == 8'd0) begin
			data = pick_packet_header();
		end
	endfunction

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	task automatic add_row(input tga_pkg::op_t op, input logic [7:0] data,
			input result_kind_t kind, input tga_pkg::pixel_t typed);
		stim_row_t entry;
		entry = '{op: op, data: data, kind: kind, typed: typed};
		directed_rows = {directed_rows, entry};
	endtask

	task automatic wait_slot();
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			gap = ($urandom_range(0, 99) < 65) ? 0 : pick_idle_length();
			if ($urandom_range(0, 99) == 0)
				send_calm = $urandom_range(50, 200);
		end
		repeat (gap) @(negedge clk) req_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic present(input tga_pkg::op_t op, input logic [7:0] data,
			input result_kind_t kind, input tga_pkg::pixel_t typed);
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.data_byte <= data;
		cur_kind = kind;
		cur_typed = typed;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	always @(posedge clk) begin : take_request
		tga_pkg::pixel_t px;
		bit has_pixel;
		if (req_ch.valid && req_ch.ready) begin
			if (!is_ignored(tga_pkg::op_t'(req_ch.operation)))
				stream_items++;
			has_pixel = decode_request(tga_pkg::op_t'(req_ch.operation),
				req_ch.data_byte, px);
			case (cur_kind)
				RES_MODEL: if (has_pixel) pending_pixels = {pending_pixels, px};
				RES_TYPED: pending_pixels = {pending_pixels, cur_typed};
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin : take_pixel
		tga_pkg::pixel_t want;
		if (pix_ch.valid && pix_ch.ready) begin
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				$display("%0t: pixel with none expected, column %0d, row %0d",
					$time, pix_ch.column, pix_ch.row);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("red", 16'(want.red), 16'(pix_ch.red));
				check_field("green", 16'(want.green), 16'(pix_ch.green));
				check_field("blue", 16'(want.blue), 16'(pix_ch.blue));
				check_field("column", want.column, pix_ch.column);
				check_field("row", want.row, pix_ch.row);
				check_field("last_pixel", 16'(want.last_pixel), 16'(pix_ch.last_pixel));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no request or pixel moved for %0d cycles",
						$time, quiet_cycles);
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	initial begin : pixel_sink
		int idle;
		int hold;
		int calm;
		bit squeezed;
		idle = 0;
		hold = 0;
		calm = 0;
		squeezed = 1'b0;
		pix_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!squeezed && pixels_seen >= 40) begin
				squeezed = 1'b1;
				hold = PRESSURE_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				pix_ch.ready <= 1'b0;
			end else if (idle > 0) begin
				idle--;
				pix_ch.ready <= 1'b0;
			end else if (calm > 0) begin
				calm--;
				pix_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 20) begin
				idle = pick_idle_length() - 1;
				pix_ch.ready <= 1'b0;
			end else begin
				pix_ch.ready <= 1'b1;
				if ($urandom_range(0, 99) == 0)
					calm = $urandom_range(50, 200);
			end
		end
	end

	initial begin : stimulus
		tga_pkg::op_t op;
		logic [7:0] data;
		logic [7:0] hdr_byte;
		req_ch.valid = 1'b0;
		req_ch.operation = tga_pkg::OP_BYTE;
		req_ch.data_byte = '0;
		stream_items = 0;
		pixels_seen = 0;
		fail_count = 0;
		quiet_cycles = 0;
		send_calm = 0;
		noise_left = 0;
		wide_left = 2;
		next_width = '0;
		next_height = '0;
		cur_kind = RES_MODEL;
		cur_typed = '0;
		dec.width = '0;
		dec.height = '0;
		dec.blue = '0;
		dec.green = '0;
		dec.red = '0;
		await_header();

		// A 1x1 image in a 128-copy repeat packet, so the image ends inside the packet.
		add_row(tga_pkg::OP_PULL, 8'h00, RES_NONE, '0);
		for (int i = 0; i < tga_pkg::HEADER_BYTES; i++) begin
			if (i == tga_pkg::HDR_WIDTH_LO || i == tga_pkg::HDR_HEIGHT_LO)
				hdr_byte = 8'd1;
			else if (i == tga_pkg::HDR_WIDTH_HI || i == tga_pkg::HDR_HEIGHT_HI)
				hdr_byte = 8'd0;
			else
				hdr_byte = 8'hFF;
			add_row(tga_pkg::OP_BYTE, hdr_byte, RES_NONE, '0);
		end
		add_row(tga_pkg::OP_BYTE, 8'hFF, RES_NONE, '0);
		add_row(tga_pkg::OP_BYTE, 8'h00, RES_NONE, '0);
		add_row(tga_pkg::OP_PULL, 8'hA5, RES_NONE, '0);
		add_row(tga_pkg::OP_BYTE, 8'hFF, RES_NONE, '0);
		add_row(tga_pkg::OP_BYTE, 8'h80, RES_NONE, '0);
		add_row(tga_pkg::OP_BYTE, 8'h3C, RES_NONE, '0);
		add_row(tga_pkg::OP_PULL, 8'h00, RES_TYPED, '{red: 8'h80, green: 8'hFF,
			blue: 8'h00, column: 16'd1, row: 16'd1, last_pixel: 1'b1});

		wait (arst_n === 1'b1);
		foreach (directed_rows[i]) begin
			wait_slot();
			present(directed_rows[i].op, directed_rows[i].data, directed_rows[i].kind,
				directed_rows[i].typed);
		end
		while (stream_items < ITEM_TARGET) begin
			wait_slot();
			choose_request(op, data);
			present(op, data, RES_MODEL, '0);
		end
		@(negedge clk) req_ch.valid <= 1'b0;

		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

FILE: filelist.f
hdl/tga_pkg.sv
hdl/tga_if.sv
hdl/tga_in_stage.sv
hdl/tga_rle_parser.sv
hdl/tga_rle_pixel_decoder_core.sv
tb/tb_top.sv
